>>> hw/rtl/lkc_pkg.sv
// Shared types and constants of the LRU key cache.
package lkc_pkg;

   localparam int ENTRIES = 16;
   localparam int KEY_W = 8;
   localparam int CAP_W = 5;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      CMD_ACCESS = 2'd0,
      CMD_DUMP   = 2'd1,
      CMD_CLEAR  = 2'd2
   } lkc_cmd_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
   } lkc_req_type;

   typedef struct packed {
      logic [KEY_W-1:0] held_key;
      logic             last;
   } lkc_rsp_type;

   // Broadcast to every cell.
   typedef struct packed {
      logic             cmp;
      logic             touch;
      logic             append;
      logic             rotate;
      logic             hit;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] wrap;
   } lkc_op_type;

   // Where a cell sits relative to the fill level.
   typedef struct packed {
      logic active;
      logic top;
      logic next;
   } lkc_pos_type;

endpackage

>>> hw/rtl/lkc_cell.sv
// One entry of the recency chain: key storage, compare and neighbour hand-off.
module lkc_cell import lkc_pkg::*; (
   input  logic             clock,
   input  lkc_op_type       op,
   input  lkc_pos_type      pos,
   input  logic [KEY_W-1:0] up_key,
   input  logic             chain_in,
   output logic             chain_out,
   output logic [KEY_W-1:0] key_out
);

   logic [KEY_W-1:0] data_ff, data_in;
   logic             seen_ff, seen_in;
   logic             match;

   assign match     = pos.active && (data_ff == op.key);
   assign chain_out = chain_in | match;
   assign key_out   = data_ff;

   always_comb begin
      data_in = data_ff;
      seen_in = op.cmp ? chain_out : seen_ff;
      if (op.touch) begin
         if (pos.top) begin
            data_in = op.key;
         end else if (pos.active && (seen_ff || !op.hit)) begin
            data_in = up_key;
         end
      end
      if (op.append && pos.next) begin
         data_in = op.key;
      end
      if (op.rotate) begin
         if (pos.top) begin
            data_in = op.wrap;
         end else if (pos.active) begin
            data_in = up_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      seen_ff <= seen_in;
   end

endmodule

>>> hw/rtl/lkc_seq.sv
// Sequencer: command decode, fill count, dump rotation and result register.
module lkc_seq import lkc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lkc_req_type      req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lkc_rsp_type      rsp_item,
   input  logic [CAP_W-1:0] capacity,
   input  logic             chain_hit,
   input  logic [KEY_W-1:0] head_key,
   output lkc_op_type       op,
   output lkc_pos_type      pos [ENTRIES]
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMP  = 4'b0010,
      ST_UPD  = 4'b0100,
      ST_DUMP = 4'b1000
   } lkc_state_type;

   lkc_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rot_ff, rot_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lkc_rsp_type      rsp_item_ff, rsp_item_in;

   logic [CMP_W-1:0] cap_x, cap_eff, cnt_x;
   logic [CNT_W-1:0] cnt_m1;
   logic             full, rot_last;

   assign cap_x    = CMP_W'(capacity);
   assign cnt_x    = CMP_W'(count_ff);
   assign cnt_m1   = count_ff - 1'b1;
   assign rot_last = (rot_ff == cnt_m1);

   always_comb begin
      if (cap_x == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_x > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_x;
      end
   end

   assign full = (cnt_x >= cap_eff);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         pos[i].active = (CNT_W'(i) < count_ff);
         pos[i].top    = (CNT_W'(i) == cnt_m1);
         pos[i].next   = (CNT_W'(i) == count_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rot_in       = rot_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      op           = '0;
      op.key       = key_ff;
      op.hit       = hit_ff;
      op.wrap      = head_key;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in = req_item.key;
               case (req_item.cmd)
                  CMD_ACCESS: state_in = ST_CMP;
                  CMD_DUMP: begin
                     rot_in = '0;
                     if (count_ff != '0) begin
                        state_in = ST_DUMP;
                     end
                  end
                  CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         ST_CMP: begin
            op.cmp   = 1'b1;
            hit_in   = chain_hit;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (hit_ff || full) begin
               op.touch = 1'b1;
            end else begin
               op.append = 1'b1;
               count_in  = CNT_W'(count_ff + 1'b1);
            end
            state_in = ST_IDLE;
         end
         ST_DUMP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op.rotate            = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_item_in.held_key = head_key;
               rsp_item_in.last     = rot_last;
               rot_in               = CNT_W'(rot_ff + 1'b1);
               if (rot_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rot_ff      <= rot_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

>>> hw/rtl/lru_key_cache_unit.sv
// Top level of the LRU key cache: register port, sequencer and the cell chain.
//
// Fully associative cache of byte keys with least-recently-used replacement.
// An access passes through a compare state across all cells and then a
// shift/update state after it is accepted, so req_ready stays low through
// both and no new item is taken until the access is done. A dump rotates
// the list through the chain one entry per cycle while rsp_ready does not
// stall it and emits one item per held key, least recent first, with last
// set on the most recent; an empty cache emits nothing. The capacity
// register at byte address 0 limits the entries in use (0 behaves as 1,
// values above the entry count saturate); lowering it below the fill level
// keeps the held keys. No start-up pass is needed after reset.
module lru_key_cache_unit import lkc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lkc_req_type           req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lkc_rsp_type           rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             csr_sel_cap;

   lkc_op_type       op;
   lkc_pos_type      pos [ENTRIES];
   logic [KEY_W-1:0] cell_key [ENTRIES];
   logic [KEY_W-1:0] up_key [ENTRIES];
   logic             chain [ENTRIES+1];

   assign csr_pready  = 1'b1;
   assign csr_sel_cap = (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);
   assign csr_prdata  = csr_sel_cap ? CSR_DATA_W'(cap_ff) : '0;

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_cap) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lkc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .capacity  (cap_ff),
      .chain_hit (chain[ENTRIES]),
      .head_key  (cell_key[0]),
      .op        (op),
      .pos       (pos)
   );

   assign chain[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == ENTRIES - 1) begin : g_top
         assign up_key[i] = op.key;
      end else begin : g_mid
         assign up_key[i] = cell_key[i+1];
      end

      lkc_cell u_cell (
         .clock     (clock),
         .op        (op),
         .pos       (pos[i]),
         .up_key    (up_key[i]),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .key_out   (cell_key[i])
      );
   end

endmodule

>>> hw/rtl/lkc_checker.sv
// Port-level checks on the LRU key cache, bound to the top level.
module lkc_checker import lkc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input lkc_req_type req_item,
   input logic        rsp_valid,
   input logic        rsp_ready
);

   logic req_acc_access;

   assign req_acc_access = req_valid && req_ready && (req_item.cmd == CMD_ACCESS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before it was taken");

   a_access_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc_access |=> !req_ready ##1 !req_ready)
      else $error("new item taken during an access");

   a_access_silent: assert property (@(posedge clock) disable iff (reset)
      req_acc_access && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("access produced a result item");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind lru_key_cache_unit lkc_checker u_lkc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

>>> test/tb.sv
// Self-checking testbench for the LRU key cache unit.
`timescale 1ns / 100ps

module tb import lkc_pkg::*; ();

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = CSR_ADDR_W'(4 * REG_CAPACITY);
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   lkc_req_type           req_item;
   logic                  rsp_valid;
   logic                  rsp_ready;
   lkc_rsp_type           rsp_item;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [KEY_W-1:0] held_keys[$];
   lkc_rsp_type      dump_queue[$];
   logic [CAP_W-1:0] cap_reg;
   int               err_count;
   int               cycle_count;
   int               rsp_hold_len;
   bit               req_gaps;
   bit               rsp_stalls;

   lru_key_cache_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lru_key_cache_unit regression: fail");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int eff_capacity();
      if (cap_reg == 0) return 1;
      if (cap_reg > ENTRIES) return ENTRIES;
      return int'(cap_reg);
   endfunction

   // Recency list: index 0 is least recent.
   task automatic update_lru(input lkc_req_type item);
      int hit_at;
      lkc_rsp_type r;
      hit_at = -1;
      case (item.cmd)
         CMD_ACCESS: begin
            foreach (held_keys[i])
               if (hit_at < 0 && held_keys[i] == item.key) hit_at = i;
            if (hit_at >= 0) held_keys.delete(hit_at);
            else if (held_keys.size() >= eff_capacity()) held_keys.delete(0);
            held_keys = {held_keys, item.key};
         end
         CMD_DUMP: begin
            foreach (held_keys[i]) begin
               r.held_key = held_keys[i];
               r.last = (i == held_keys.size() - 1);
               dump_queue = {dump_queue, r};
            end
         end
         CMD_CLEAR: held_keys.delete();
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
      int gap;
      lkc_req_type item;
      item.cmd = cmd;
      item.key = key;
      gap = req_gaps ? idle_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
      update_lru(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (dump_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write, then read back.
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      wait_idle();
      for (int pass = 0; pass < 2; pass++) begin
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= (pass == 0);
         csr_paddr   <= CAP_ADDR;
         csr_pwdata  <= CSR_DATA_W'(value);
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (pass == 0) begin
            cap_reg = value;
         end else if (csr_prdata[CAP_W-1:0] !== value) begin
            $error("capacity: expected %0d, got %0d", value, csr_prdata[CAP_W-1:0]);
            err_count++;
         end
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   always @(posedge clock) begin
      lkc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dump_queue.size() == 0) begin
            $error("unexpected item: held_key %0h last %0b", rsp_item.held_key, rsp_item.last);
            err_count++;
         end else begin
            want = dump_queue.pop_front();
            if (rsp_item.held_key !== want.held_key) begin
               $error("held_key: expected %0h, got %0h", want.held_key, rsp_item.held_key);
               err_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_item.last);
               err_count++;
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when asked.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            stall = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            stall = rsp_stalls ? idle_len() : 0;
         end
         rsp_ready <= (stall == 0);
         for (int n = 1; n < stall; n++) @(negedge clock);
      end
   end

   task automatic test_commands();
      req_gaps   = 1'b0;
      rsp_stalls = 1'b0;
      send_item(CMD_DUMP, 8'h00);
      send_item(CMD_ACCESS, 8'h00);
      send_item(CMD_ACCESS, 8'hFF);
      send_item(CMD_ACCESS, 8'h55);
      send_item(CMD_ACCESS, 8'h00);
      send_item(CMD_ACCESS, 8'hAA);
      send_item(CMD_ACCESS, 8'hAA);
      send_item(CMD_UNUSED, 8'h5A);
      send_item(CMD_DUMP, 8'hFF);
      send_item(CMD_CLEAR, 8'h55);
      send_item(CMD_DUMP, 8'h00);
      send_item(CMD_UNUSED, 8'hA5);
      send_item(CMD_DUMP, 8'h00);
   endtask

   task automatic test_small_capacity();
      set_capacity(5'd1);
      send_item(CMD_ACCESS, 8'h11);
      send_item(CMD_ACCESS, 8'h22);
      send_item(CMD_DUMP, 8'h00);
      set_capacity(5'd0);
      send_item(CMD_ACCESS, 8'h33);
      send_item(CMD_ACCESS, 8'h33);
      send_item(CMD_DUMP, 8'h00);
      set_capacity(5'd2);
      send_item(CMD_ACCESS, 8'h44);
      send_item(CMD_ACCESS, 8'h55);
      send_item(CMD_ACCESS, 8'h44);
      send_item(CMD_DUMP, 8'h00);
   endtask

   // Saturated capacity, full cache, then a long receiver hold-off.
   task automatic test_backpressure();
      set_capacity(5'd31);
      send_item(CMD_CLEAR, 8'h00);
      for (int i = 0; i < ENTRIES + 1; i++) send_item(CMD_ACCESS, 8'(8'h80 + 5 * i));
      rsp_hold_len = 300;
      repeat (4) send_item(CMD_DUMP, 8'h00);
   endtask

   // Capacity lowered under the fill level keeps the held keys.
   task automatic test_shrink();
      set_capacity(5'd4);
      send_item(CMD_ACCESS, 8'h01);
      send_item(CMD_ACCESS, 8'h85);
      send_item(CMD_DUMP, 8'h00);
      set_capacity(5'd17);
      send_item(CMD_ACCESS, 8'h02);
      send_item(CMD_DUMP, 8'h00);
   endtask

   task automatic random_phase(input logic [CAP_W-1:0] cap, input int count,
                               input int key_hi, input bit gaps, input bit stalls);
      int r;
      set_capacity(cap);
      req_gaps   = gaps;
      rsp_stalls = stalls;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80) send_item(CMD_ACCESS, 8'($urandom_range(0, key_hi)));
         else if (r < 92) send_item(CMD_DUMP, 8'($urandom_range(0, 255)));
         else if (r < 96) send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
         else send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random();
      random_phase(5'd16, 45, 24, 1'b1, 1'b1);
      random_phase(5'd3, 35, 6, 1'b1, 1'b0);
      random_phase(5'd1, 30, 3, 1'b0, 1'b1);
      random_phase(5'd8, 45, 255, 1'b0, 1'b0);
      random_phase(5'($urandom_range(0, 31)), 45, 31, 1'b1, 1'b1);
      random_phase(CAP_RESET, 30, 20, 1'b1, 1'b1);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_item     = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      cap_reg      = CAP_RESET;
      err_count    = 0;
      cycle_count  = 0;
      rsp_hold_len = 0;
      req_gaps     = 1'b0;
      rsp_stalls   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_commands();
      test_small_capacity();
      test_backpressure();
      test_shrink();
      test_random();

      wait_idle();
      if (err_count == 0) begin
         $display("lru_key_cache_unit regression: pass");
      end else begin
         $display("lru_key_cache_unit regression: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/lkc_pkg.sv
hw/rtl/lkc_cell.sv
hw/rtl/lkc_seq.sv
hw/rtl/lru_key_cache_unit.sv
hw/rtl/lkc_checker.sv
test/tb.sv
